>>> src/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants for integer_to_base_digits
// Field widths, radix limits, ASCII digit mapping, the controller state type
// and the command and status words between the controller and the divider.
// ----------------------------------------------------------------------------
package itd_pkg;

   // payload widths fixed by the channel definitions
   localparam int IN_VALUE_W     = 64;
   localparam int IN_RADIX_W     = 8;
   localparam int CHAR_W         = 7;
   localparam int DIGIT_TOTAL_W  = 7;
   localparam int DIGIT_W        = 6;

   // accepted radix range and digit mapping
   localparam logic [IN_RADIX_W-1:0] RADIX_MIN     = 8'd2;
   localparam logic [IN_RADIX_W-1:0] RADIX_MAX     = 8'd36;
   localparam logic [DIGIT_W-1:0]    DECIMAL_LIMIT = 6'd10;
   localparam logic [CHAR_W-1:0]     ASCII_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0]     ASCII_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0]     ERROR_CHAR    = 7'h00;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_LOAD,
      ST_ERROR
   } itd_state_type;

   // command word into the bit-serial divider
   typedef struct packed {
      logic               start;
      logic [DIGIT_W-1:0] divisor;
   } itd_div_cmd_type;

   // status word out of the bit-serial divider
   typedef struct packed {
      logic               done;
      logic               nonzero;
      logic [DIGIT_W-1:0] remainder;
   } itd_div_stat_type;

   // map a remainder to its ASCII digit
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < DECIMAL_LIMIT) begin
         return ASCII_ZERO + d_ext;
      end else begin
         return ASCII_UPPER_A + d_ext - CHAR_W'(DECIMAL_LIMIT);
      end
   endfunction

endpackage

>>> src/itd_req_if.sv
// ----------------------------------------------------------------------------
// itd_req_if: request channel
// Carries one number and its radix per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface itd_req_if
   import itd_pkg::*;
();

   logic                  valid;
   logic                  ready;
   logic [IN_VALUE_W-1:0] value;
   logic [IN_RADIX_W-1:0] radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);

endinterface

>>> src/itd_rsp_if.sv
// ----------------------------------------------------------------------------
// itd_rsp_if: response channel
// Carries one ASCII digit per word with last, digit total and error flag.
// ----------------------------------------------------------------------------
interface itd_rsp_if
   import itd_pkg::*;
();

   logic                     valid;
   logic                     ready;
   logic [CHAR_W-1:0]        character;
   logic                     last;
   logic [DIGIT_TOTAL_W-1:0] digit_total;
   logic                     bad_radix;

   modport source (output valid, output character, output last, output digit_total,
                   output bad_radix, input ready);
   modport sink   (input valid, input character, input last, input digit_total,
                   input bad_radix, output ready);

endinterface

>>> src/integer_to_base_digits.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits: unsigned integer to radix digit string
// Converts the low VALUE_WIDTH bits of each request word to ASCII digits in
// the requested base, most significant digit first, one response per digit.
// ----------------------------------------------------------------------------
// One number is converted at a time. A bit-serial divider produces one
// quotient bit per cycle; the remainders go to a digit store and are then
// read back most significant first, each digit through the READ and LOAD
// states, waiting in LOAD while the response side stalls. The number of
// digits is capped at MAX_DIGITS. A radix outside 2..36 gives one response
// with bad_radix set, character 0 and digit_total 0. The request side is
// ready again as soon as the final response word is in the output register;
// zero converts to a single '0'. When MAX_DIGITS is below the digits a value
// needs, only the least significant MAX_DIGITS digits are produced.
// ----------------------------------------------------------------------------
module integer_to_base_digits
   import itd_pkg::*;
#(
   parameter int MAX_DIGITS  = 64,
   parameter int VALUE_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   itd_req_if.sink    req_chan,
   itd_rsp_if.source  rsp_chan
);

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   itd_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [DIGIT_W-1:0]     radix_ff, radix_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [DIGIT_TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                     rsp_bad_ff, rsp_bad_in;

   itd_div_cmd_type        div_cmd;
   itd_div_stat_type       div_stat;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;

   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [DIGIT_W-1:0]     ram_rd_data;

   logic                   accept;
   logic                   radix_bad;
   logic                   out_free;
   logic [CNT_W-1:0]       count_next;

   assign accept     = req_chan.valid && req_chan.ready;
   assign radix_bad  = (req_chan.radix < RADIX_MIN) || (req_chan.radix > RADIX_MAX);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign count_next = count_ff + CNT_W'(1);

   // feed the divider from the request while idle, else from its own quotient
   assign div_dividend = (state_ff == ST_IDLE) ? req_chan.value[VALUE_WIDTH-1:0]
                                               : div_quotient;

   itd_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   itd_digit_ram #(
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_stat.remainder),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // next state, divider commands, store access and output word
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      total_in        = total_ff;
      idx_in          = idx_ff;
      radix_in        = radix_ff;
      div_cmd.start   = 1'b0;
      div_cmd.divisor = radix_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      req_chan.ready  = 1'b0;

      // drop the output word once taken
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_total_in = rsp_total_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready  = 1'b1;
            div_cmd.divisor = req_chan.radix[DIGIT_W-1:0];
            if (accept) begin
               count_in = '0;
               radix_in = req_chan.radix[DIGIT_W-1:0];
               if (radix_bad) begin
                  state_in = ST_ERROR;
               end else begin
                  div_cmd.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            // store each remainder, restart on the quotient until it runs out or the store is full
            if (div_stat.done) begin
               ram_wr_en = 1'b1;
               count_in  = count_next;
               if (div_stat.nonzero && (count_next != CNT_W'(MAX_DIGITS))) begin
                  div_cmd.start = 1'b1;
               end else begin
                  total_in = count_next;
                  idx_in   = count_ff[ADDR_W-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // hold the digit until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(ram_rd_data);
               rsp_last_in  = (idx_ff == '0);
               rsp_total_in = DIGIT_TOTAL_W'(total_ff);
               rsp_bad_in   = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ERROR_CHAR;
               rsp_last_in  = 1'b1;
               rsp_total_in = '0;
               rsp_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff     <= total_in;
      idx_ff       <= idx_in;
      radix_ff     <= radix_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.character   = rsp_char_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.digit_total = rsp_total_ff;
   assign rsp_chan.bad_radix   = rsp_bad_ff;

endmodule

>>> src/itd_divider.sv
// ----------------------------------------------------------------------------
// itd_divider: bit-serial restoring divider
// Divides a VALUE_WIDTH-bit dividend by a small radix, one quotient bit per
// cycle. Reports remainder and whether the quotient is nonzero on done.
// ----------------------------------------------------------------------------
module itd_divider
   import itd_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itd_div_cmd_type        cmd,
   input  logic [VALUE_WIDTH-1:0] dividend,
   output itd_div_stat_type       stat,
   output logic [VALUE_WIDTH-1:0] quotient
);

   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [DIGIT_W-1:0]     divisor_ff, divisor_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   nz_ff, nz_in;

   logic [DIGIT_W:0]       trial;
   logic [DIGIT_W:0]       diff;
   logic                   take;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      take  = (trial >= {1'b0, divisor_ff});
   end

   // sequence the steps
   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      bit_cnt_in = bit_cnt_ff;
      busy_in    = busy_ff;
      nz_in      = nz_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
         bit_cnt_in = '0;
         busy_in    = 1'b1;
         nz_in      = 1'b0;
      end else if (busy_ff) begin
         quot_in    = {quot_ff[VALUE_WIDTH-2:0], take};
         rem_in     = take ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         nz_in      = nz_ff | take;
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         if (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      bit_cnt_ff <= bit_cnt_in;
      nz_ff      <= nz_in;
   end

   assign stat.done      = done_ff;
   assign stat.nonzero   = nz_ff;
   assign stat.remainder = rem_ff;
   assign quotient       = quot_ff;

endmodule

>>> src/itd_digit_ram.sv
// ----------------------------------------------------------------------------
// itd_digit_ram: digit store
// One write port and one registered read port, DEPTH entries of one digit.
// ----------------------------------------------------------------------------
module itd_digit_ram
   import itd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DIGIT_W-1:0]       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DIGIT_W-1:0]       rd_data
);

   logic [DIGIT_W-1:0] mem_ff [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/integer_to_base_digits_tb.sv
// ----------------------------------------------------------------------------
// integer_to_base_digits_tb: self-checking bench for the radix digit converter
// Sends numbers with their radix on the request channel, predicts the ASCII
// digit words for each accepted request and checks every response word in
// order, with bursty requests, a response side that stalls and long hold-offs.
// ----------------------------------------------------------------------------
module integer_to_base_digits_tb;
   import itd_pkg::*;

   localparam int MAX_DIGITS     = 64;
   localparam int VALUE_WIDTH    = 64;
   localparam int RANDOM_NUMBERS = 116;
   localparam int HOLD_CYCLES    = 1500;
   localparam int DRAIN_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic [CHAR_W-1:0]        character;
      logic                     last;
      logic [DIGIT_TOTAL_W-1:0] digit_total;
      logic                     bad_radix;
   } digit_word_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_SPARSE
   } stall_mode_type;

   // Expected digit words in emission order, built from each accepted number
   class digit_scoreboard;
      digit_word_type expected_digits[$];
      int          errors;
      int          numbers_seen;
      int          bad_radix_seen;
      int          digits_checked;
      logic [36:0] radix_seen;

      function new();
         errors         = 0;
         numbers_seen   = 0;
         bad_radix_seen = 0;
         digits_checked = 0;
         radix_seen     = '0;
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction

      // Divide out the digits, then queue them most significant first
      function void note_request(logic [IN_VALUE_W-1:0] value, logic [IN_RADIX_W-1:0] radix);
         logic [DIGIT_W-1:0]    remainders [MAX_DIGITS];
         logic [IN_VALUE_W-1:0] quot;
         logic [DIGIT_W-1:0]    d;
         digit_word_type        w;
         int                    n;

         numbers_seen++;
         quot = value & ({IN_VALUE_W{1'b1}} >> (IN_VALUE_W - VALUE_WIDTH));
         if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            bad_radix_seen++;
            w.character   = ERROR_CHAR;
            w.last        = 1'b1;
            w.digit_total = '0;
            w.bad_radix   = 1'b1;
            expected_digits.push_back(w);
            return;
         end
         radix_seen[radix] = 1'b1;
         n = 0;
         do begin
            if (n >= MAX_DIGITS) break;
            remainders[n] = DIGIT_W'(quot % IN_VALUE_W'(radix));
            quot          = quot / IN_VALUE_W'(radix);
            n++;
         end while (quot != 0);
         for (int k = 0; k < n; k++) begin
            d = remainders[n - 1 - k];
            if (d < DECIMAL_LIMIT) begin
               w.character = ASCII_ZERO + CHAR_W'(d);
            end else begin
               w.character = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_LIMIT);
            end
            w.last        = (k == n - 1);
            w.digit_total = DIGIT_TOTAL_W'(n);
            w.bad_radix   = 1'b0;
            expected_digits.push_back(w);
         end
      endfunction

      // Compare one response word against the oldest expectation
      function void check_digit(digit_word_type got);
         digit_word_type want;

         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected word char=%h last=%b total=%0d bad=%b", $time,
                     got.character, got.last, got.digit_total, got.bad_radix);
            errors++;
            return;
         end
         want = expected_digits.pop_front();
         digits_checked++;
         if (got.character !== want.character) begin
            $display("%0t: character expected %h got %h", $time, want.character,
                     got.character);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, got.last);
            errors++;
         end
         if (got.digit_total !== want.digit_total) begin
            $display("%0t: digit_total expected %0d got %0d", $time, want.digit_total,
                     got.digit_total);
            errors++;
         end
         if (got.bad_radix !== want.bad_radix) begin
            $display("%0t: bad_radix expected %b got %b", $time, want.bad_radix,
                     got.bad_radix);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   itd_req_if req_bus ();
   itd_rsp_if rsp_bus ();

   digit_scoreboard sb = new();

   int   burst_left  = 0;
   int   idle_cycles = 0;
   logic [3:0] hold_req = '0;

   integer_to_base_digits #(
      .MAX_DIGITS  (MAX_DIGITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one number; start a new burst, sometimes after a gap, when the current one is used up
   task automatic send_number(input logic [IN_VALUE_W-1:0] value,
                              input logic [IN_RADIX_W-1:0] radix);
      int gap;

      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.radix <= radix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // Record accepted numbers and check response words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.value, req_bus.radix);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_digit({rsp_bus.character, rsp_bus.last, rsp_bus.digit_total,
                            rsp_bus.bad_radix});
         end
      end
   end

   // Abort when no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d words outstanding", $time,
                     sb.pending());
            $display("integer_to_base_digits_tb: done, errors");
            $finish;
         end
      end
   end

   // Response side: switch stall patterns, hold off for a long stretch on request
   initial begin
      stall_mode_type mode;
      int             phase_left;
      int             hold_left;
      logic [3:0]     hold_seen;

      mode       = STALL_NONE;
      phase_left = 0;
      hold_left  = 0;
      hold_seen  = '0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               mode       = stall_mode_type'($urandom_range(0, 2));
               phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            case (mode)
               STALL_NONE:   rsp_bus.ready <= 1'b1;
               STALL_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               default:      rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Stimulus: directed corners, then random numbers, then drain and report
   initial begin
      logic [IN_VALUE_W-1:0] value;
      logic [IN_RADIX_W-1:0] radix;
      int                    len;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.radix <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, one and the largest value in the common bases
      send_number(64'd0, 8'd2);
      send_number(64'd0, 8'd10);
      send_number(64'd0, 8'd36);
      send_number(64'd1, 8'd2);
      send_number({64{1'b1}}, 8'd2);
      send_number({64{1'b1}}, 8'd3);
      send_number({64{1'b1}}, 8'd8);
      send_number({64{1'b1}}, 8'd10);
      send_number({64{1'b1}}, 8'd16);
      send_number({64{1'b1}}, 8'd36);
      send_number(64'h8000_0000_0000_0000, 8'd2);
      // digit boundaries: nine to ten, first letter, last letter
      send_number(64'd9, 8'd10);
      send_number(64'd10, 8'd11);
      send_number(64'd35, 8'd36);
      send_number(64'd36, 8'd36);
      send_number(64'd1295, 8'd36);
      send_number(64'd255, 8'd16);
      send_number(64'h0123_4567_89AB_CDEF, 8'd16);
      send_number(64'd123456789, 8'd7);
      // out-of-range radix on both sides and with all radix bits set
      send_number({64{1'b1}}, 8'd0);
      send_number(64'd5, 8'd1);
      send_number({64{1'b1}}, 8'd37);
      send_number(64'd0, 8'd255);
      send_number(64'hDEAD_BEEF, 8'd128);

      // hold the response side while requests keep coming
      hold_req <= hold_req + 1'b1;
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         if (i == RANDOM_NUMBERS / 2) begin
            hold_req <= hold_req + 1'b1;
         end
         len   = $urandom_range(0, 64);
         value = {$urandom, $urandom};
         if (len < 64) begin
            value = value & ((64'd1 << len) - 64'd1);
         end
         if ($urandom_range(0, 7) == 0) begin
            radix = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1))
                                                : 8'($urandom_range(37, 255));
         end else begin
            radix = 8'($urandom_range(2, 36));
         end
         send_number(value, radix);
      end
      req_bus.valid <= 1'b0;

      // let the last accepted number reach the scoreboard, drain, watch for strays
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d numbers (%0d with an out-of-range radix), %0d digit words",
               sb.numbers_seen, sb.bad_radix_seen, sb.digits_checked);
      $display("valid radices exercised: %0d of 35", $countones(sb.radix_seen));
      if (sb.errors == 0) begin
         $display("integer_to_base_digits_tb: done, clean");
      end else begin
         $display("integer_to_base_digits_tb: done, errors");
      end
      $finish;
   end

endmodule
